>>> hw/rtl/rlse_pkg.sv
// rlse_pkg: shared constants, types and codes for the rgb led strip spi encoder
// used by every rtl file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rlse_pkg;

  localparam int LED_COUNT_DEF      = 64;
  localparam int PREAMBLE_BYTES_DEF = 120;

  localparam int INDEX_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int BIT_W      = 5;
  localparam int MODE_W     = 2;
  localparam int PERMILLE_W = 10;
  localparam int PAT_W      = 8;
  localparam int PROD_W     = CHAN_W + PERMILLE_W;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [BIT_W-1:0]      BIT_TOP       = 5'd23;
  localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = 10'd1000;
  localparam logic [CHAN_W-1:0]     DIV_MAX       = 8'd255;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRESERVE = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_PERMILLE = 2'd1;
  localparam logic [1:0] REG_ZERO_PAT = 2'd2;
  localparam logic [1:0] REG_ONE_PAT  = 2'd3;

  localparam logic [MODE_W-1:0]     MODE_RST     = MODE_PRESERVE;
  localparam logic [PERMILLE_W-1:0] PERMILLE_RST = 10'd5;
  localparam logic [PAT_W-1:0]      ZERO_PAT_RST = 8'd96;
  localparam logic [PAT_W-1:0]      ONE_PAT_RST  = 8'd248;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [PERMILLE_W-1:0] permille;
    logic [PAT_W-1:0]      zero_pat;
    logic [PAT_W-1:0]      one_pat;
  } cfg_t;

  typedef enum logic [2:0] {
    DSEL_C,
    DSEL_D,
    DSEL_G,
    DSEL_R,
    DSEL_B
  } dsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PULL_RD,
    ST_PULL_OUT,
    ST_SET_MUL,
    ST_SET_SCALE,
    ST_DIV_D,
    ST_DIV_G,
    ST_DIV_R,
    ST_DIV_B,
    ST_SET_WR
  } state_t;

  typedef struct packed {
    logic  clr_en;
    logic  take;
    logic  mul_en;
    logic  div_start;
    dsel_t div_sel;
    logic  div_latch;
    logic  mem_wr;
    logic  mem_rd;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } ctrl_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/rlse_if.sv
// rlse_in_if and rlse_out_if: valid/ready channels for the encoder words
// depends on rlse_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rlse_in_if import rlse_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [INDEX_W-1:0] led_index;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, cmd, led_index, red_in, green_in, blue_in, input ready);
  modport sink (input valid, cmd, led_index, red_in, green_in, blue_in, output ready);
endinterface

interface rlse_out_if import rlse_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PAT_W-1:0] spi_byte;
  logic             last_of_frame;

  modport source (output valid, spi_byte, last_of_frame, input ready);
  modport sink (input valid, spi_byte, last_of_frame, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rlse_regs.sv
// rlse_regs: apb configuration registers (mode, permille, bit patterns)
// depends on rlse_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlse_regs import rlse_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RST;
      cfg.permille <= PERMILLE_RST;
      cfg.zero_pat <= ZERO_PAT_RST;
      cfg.one_pat  <= ONE_PAT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:     cfg.mode     <= pwdata[MODE_W-1:0];
        REG_PERMILLE: cfg.permille <= pwdata[PERMILLE_W-1:0];
        REG_ZERO_PAT: cfg.zero_pat <= pwdata[PAT_W-1:0];
        REG_ONE_PAT:  cfg.one_pat  <= pwdata[PAT_W-1:0];
        default:      cfg.mode     <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:     prdata = APB_DATA_W'(cfg.mode);
      REG_PERMILLE: prdata = APB_DATA_W'(cfg.permille);
      REG_ZERO_PAT: prdata = APB_DATA_W'(cfg.zero_pat);
      REG_ONE_PAT:  prdata = APB_DATA_W'(cfg.one_pat);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/rlse_div.sv
// rlse_div: radix-2 restoring divider, one quotient bit per cycle
// depends on rlse_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module rlse_div import rlse_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [PROD_W-1:0]     dividend,
  input  wire logic [PERMILLE_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic      [PROD_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  logic [CNT_W-1:0]      cnt;
  logic [PERMILLE_W-1:0] rem;
  logic [PERMILLE_W-1:0] dsr;
  logic [PERMILLE_W:0]   rem_sh;
  logic [PERMILLE_W:0]   rem_sub;
  logic                  q_bit;

  assign rem_sh  = {rem, quotient[PROD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dsr};
  assign rem_sub = q_bit ? (rem_sh - {1'b0, dsr}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_sub[PERMILLE_W-1:0];
      quotient <= {quotient[PROD_W-2:0], q_bit};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rlse_dp.sv
// rlse_dp: datapath with pixel memory, dimming arithmetic, frame counters
// and output register; depends on rlse_pkg and rlse_div
`timescale 1ns / 1ps
`default_nettype none

module rlse_dp import rlse_pkg::*; #(
  parameter int LED_COUNT      = LED_COUNT_DEF,
  parameter int PREAMBLE_BYTES = PREAMBLE_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_status_t            status,
  input  wire cfg_t               cfg,
  input  wire logic [INDEX_W-1:0] in_led_index,
  input  wire logic [CHAN_W-1:0]  in_red,
  input  wire logic [CHAN_W-1:0]  in_green,
  input  wire logic [CHAN_W-1:0]  in_blue,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic      [PAT_W-1:0]   out_spi_byte,
  output logic                    out_last
);

  localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int PRE_W  = $clog2(PREAMBLE_BYTES + 1);
  localparam logic [LED_AW-1:0]  LED_LAST  = LED_AW'(LED_COUNT - 1);
  localparam logic [PRE_W-1:0]   PRE_LAST  = PRE_W'(PREAMBLE_BYTES - 1);
  localparam logic [INDEX_W:0]   LED_LIMIT = (INDEX_W + 1)'(LED_COUNT);

  localparam int                 RECIP_W    = 17;
  localparam int                 RECIP_SH   = 26;
  localparam int                 SCALE_W    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 17'd67109;

  logic [LED_AW-1:0] idx_q;
  logic [CHAN_W-1:0] r_q, g_q, b_q;
  logic [CHAN_W-1:0] m_c, m_q;
  logic [PROD_W-1:0] prod_q;
  logic [CHAN_W-1:0] c_q, d_q;
  logic [CHAN_W-1:0] gd_q, rd_q, bd_q;

  logic [PROD_W-1:0]     dvd;
  logic [PERMILLE_W-1:0] dvs;
  logic [PROD_W-1:0]     quot;
  logic                  div_busy, div_done;

  logic [SCALE_W-1:0] scale_full;
  logic [CHAN_W:0]    c_raw, c_nz;
  logic [CHAN_W-1:0]  c_calc, d_calc;

  logic [PIX_W-1:0]  mem [LED_COUNT];
  logic [PIX_W-1:0]  rd_word;
  logic [LED_AW-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;
  logic [LED_AW-1:0] clr_cnt;

  logic              in_pre;
  logic [PRE_W-1:0]  pre_cnt;
  logic [LED_AW-1:0] led_cnt;
  logic [BIT_W-1:0]  bit_cnt;
  logic              frame_last;

  // smallest nonzero channel, zero when all are zero
  always_comb begin
    m_c = r_q;
    if ((g_q != '0) && ((m_c == '0) || (g_q < m_c))) m_c = g_q;
    if ((b_q != '0) && ((m_c == '0) || (b_q < m_c))) m_c = b_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_q <= in_led_index[LED_AW-1:0];
      r_q   <= in_red;
      g_q   <= in_green;
      b_q   <= in_blue;
    end
    if (cmd.mul_en) begin
      m_q    <= m_c;
      prod_q <= PROD_W'(m_c) * PROD_W'(cfg.permille);
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_C: begin
        dvd = '0;
        dvs = '0;
      end
      DSEL_D: begin
        if (cfg.mode == MODE_FIXED) begin
          dvd = PROD_W'(PERMILLE_FULL);
          dvs = cfg.permille;
        end else begin
          dvd = PROD_W'(m_q);
          dvs = PERMILLE_W'(c_q);
        end
      end
      DSEL_G: begin
        dvd = PROD_W'(g_q);
        dvs = PERMILLE_W'(d_q);
      end
      DSEL_R: begin
        dvd = PROD_W'(r_q);
        dvs = PERMILLE_W'(d_q);
      end
      DSEL_B: begin
        dvd = PROD_W'(b_q);
        dvs = PERMILLE_W'(d_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  rlse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // c = max(1, m*p/1000) limited to m; the /1000 is a reciprocal multiply,
  // exact over the whole product range
  assign scale_full = SCALE_W'(prod_q) * SCALE_W'(RECIP_1000);
  assign c_raw      = scale_full[RECIP_SH +: CHAN_W + 1];
  assign c_nz       = (c_raw == '0) ? (CHAN_W + 1)'(1) : c_raw;
  assign c_calc     = (c_nz > {1'b0, m_q}) ? m_q : c_nz[CHAN_W-1:0];

  always_comb begin
    unique case (cfg.mode)
      MODE_FIXED: begin
        if (cfg.permille == '0) d_calc = DIV_MAX;
        else if (quot > PROD_W'(DIV_MAX)) d_calc = DIV_MAX;
        else if (quot == '0) d_calc = CHAN_W'(1);
        else d_calc = quot[CHAN_W-1:0];
      end
      MODE_PRESERVE: begin
        d_calc = (m_q == '0) ? CHAN_W'(1) : quot[CHAN_W-1:0];
      end
      default: d_calc = CHAN_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_latch) begin
      unique case (cmd.div_sel)
        DSEL_C:  c_q  <= c_calc;
        DSEL_D:  d_q  <= d_calc;
        DSEL_G:  gd_q <= quot[CHAN_W-1:0];
        DSEL_R:  rd_q <= quot[CHAN_W-1:0];
        DSEL_B:  bd_q <= quot[CHAN_W-1:0];
        default: c_q  <= c_q;
      endcase
    end
  end

  // pixel memory, cleared by a sweep after reset
  assign wr_addr = cmd.clr_en ? clr_cnt : idx_q;
  assign wr_data = cmd.clr_en ? '0 : {gd_q, rd_q, bd_q};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_word <= mem[led_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_en) clr_cnt <= clr_cnt + 1'b1;
  end

  // frame position as preamble count, led and bit within the led
  assign frame_last = !in_pre && (bit_cnt == '0) && (led_cnt == LED_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pre  <= 1'b1;
      pre_cnt <= '0;
      led_cnt <= '0;
      bit_cnt <= BIT_TOP;
    end else if (cmd.out_load) begin
      if (in_pre) begin
        if (pre_cnt == PRE_LAST) in_pre <= 1'b0;
        else pre_cnt <= pre_cnt + 1'b1;
      end else if (bit_cnt == '0) begin
        bit_cnt <= BIT_TOP;
        if (led_cnt == LED_LAST) begin
          led_cnt <= '0;
          in_pre  <= 1'b1;
          pre_cnt <= '0;
        end else begin
          led_cnt <= led_cnt + 1'b1;
        end
      end else begin
        bit_cnt <= bit_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (in_pre) out_spi_byte <= '0;
      else out_spi_byte <= rd_word[bit_cnt] ? cfg.one_pat : cfg.zero_pat;
      out_last <= frame_last;
    end
  end

  assign status.clr_done = (clr_cnt == LED_LAST);
  assign status.in_range = ({1'b0, in_led_index} < LED_LIMIT);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> hw/rtl/rlse_ctrl.sv
// rlse_ctrl: controller state machine sequencing clear, pull and set-pixel
// depends on rlse_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlse_ctrl import rlse_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_cmd,
  output logic              in_ready,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (status.clr_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_PULL) state_next = ST_PULL_RD;
          else if (status.in_range) state_next = ST_SET_MUL;
        end
      end
      ST_PULL_RD:   state_next = ST_PULL_OUT;
      ST_PULL_OUT:  if (!status.out_busy) state_next = ST_IDLE;
      ST_SET_MUL:   state_next = ST_SET_SCALE;
      ST_SET_SCALE: state_next = ST_DIV_D;
      ST_DIV_D:     if (status.div_done) state_next = ST_DIV_G;
      ST_DIV_G:     if (status.div_done) state_next = ST_DIV_R;
      ST_DIV_R:     if (status.div_done) state_next = ST_DIV_B;
      ST_DIV_B:     if (status.div_done) state_next = ST_SET_WR;
      ST_SET_WR:    state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.clr_en    = 1'b0;
    cmd.take      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DSEL_C;
    cmd.div_latch = 1'b0;
    cmd.mem_wr    = 1'b0;
    cmd.mem_rd    = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        cmd.mem_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid && (in_cmd == CMD_SET) && status.in_range;
      end
      ST_PULL_RD:  cmd.mem_rd = 1'b1;
      ST_PULL_OUT: cmd.out_load = !status.out_busy;
      ST_SET_MUL:  cmd.mul_en = 1'b1;
      ST_SET_SCALE: begin
        cmd.div_sel   = DSEL_C;
        cmd.div_latch = 1'b1;
      end
      ST_DIV_D, ST_DIV_G, ST_DIV_R, ST_DIV_B: begin
        unique case (state)
          ST_DIV_G: cmd.div_sel = DSEL_G;
          ST_DIV_R: cmd.div_sel = DSEL_R;
          ST_DIV_B: cmd.div_sel = DSEL_B;
          default:  cmd.div_sel = DSEL_D;
        endcase
        cmd.div_start = !status.div_busy && !status.div_done;
        cmd.div_latch = status.div_done;
      end
      ST_SET_WR:   cmd.mem_wr = 1'b1;
      default:     in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/rgb_led_strip_spi_encoder.sv
// Encodes a pixel store into a WS2812-style SPI byte stream. A pull word
// does one pixel memory read, then the output register load (which waits
// while the register still holds a byte), and returns the next frame byte:
// PREAMBLE_BYTES zero bytes, then G, R, B of every LED, MSB first, one
// pattern byte per color bit, last byte flagged. A set-pixel word does one
// multiply, one reciprocal multiply for the permille scale, then four
// 18-step divisions (divisor, three channels) run in turn through one shared
// bit-serial divider, then the memory write. After reset the pixel memory is
// cleared in a sweep over all LED_COUNT entries during which no word is
// accepted; configuration writes are taken throughout. The finished byte sits
// in an output register, so the next word is accepted while it waits.
// depends on rlse_pkg, rlse_if, rlse_regs, rlse_div, rlse_dp, rlse_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_strip_spi_encoder import rlse_pkg::*; #(
  parameter int LED_COUNT      = LED_COUNT_DEF,
  parameter int PREAMBLE_BYTES = PREAMBLE_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rlse_in_if.sink                    din,
  rlse_out_if.source                 dout,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t         cfg;
  ctrl_cmd_t    ctl_cmd;
  ctrl_status_t ctl_st;

  rlse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_cmd   (din.cmd),
    .in_ready (din.ready),
    .status   (ctl_st),
    .cmd      (ctl_cmd)
  );

  rlse_dp #(
    .LED_COUNT      (LED_COUNT),
    .PREAMBLE_BYTES (PREAMBLE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl_cmd),
    .status       (ctl_st),
    .cfg          (cfg),
    .in_led_index (din.led_index),
    .in_red       (din.red_in),
    .in_green     (din.green_in),
    .in_blue      (din.blue_in),
    .out_ready    (dout.ready),
    .out_valid    (dout.valid),
    .out_spi_byte (dout.spi_byte),
    .out_last     (dout.last_of_frame)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.out_load |-> !ctl_st.out_busy)
    else $error("output register loaded while still holding a word");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.div_start |-> !ctl_st.div_busy)
    else $error("divider started while busy");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(ctl_cmd.out_load))
    else $error("output valid rose without a load");

endmodule

`default_nettype wire

>>> bench/tb_rgb_led_strip_spi_encoder.sv
`timescale 1ns / 1ps
// tb_rgb_led_strip_spi_encoder: self-checking bench that predicts every spi frame byte
// from its own pixel store, register copies and frame cursor
// depends on rlse_pkg, rlse_if and the rgb_led_strip_spi_encoder rtl

module tb_rgb_led_strip_spi_encoder;
  import rlse_pkg::*;

  localparam int FRAME_LEN   = PREAMBLE_BYTES_DEF + LED_COUNT_DEF * PIX_W;
  localparam int SETTLE      = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int WORD_GOAL   = 2000;
  localparam int PHASE_WORDS = 300;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [PAT_W-1:0] spi_byte;
    logic             last_of_frame;
  } frame_byte_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rlse_in_if  din_if ();
  rlse_out_if dout_if ();

  rgb_led_strip_spi_encoder u_top (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [MODE_W-1:0]     cfg_mode     = MODE_RST;
  logic [PERMILLE_W-1:0] cfg_permille = PERMILLE_RST;
  logic [PAT_W-1:0]      cfg_zero     = ZERO_PAT_RST;
  logic [PAT_W-1:0]      cfg_one      = ONE_PAT_RST;
  logic [PIX_W-1:0]      led_colors [LED_COUNT_DEF];
  int unsigned           byte_cursor = 0;
  frame_byte_t           frame_bytes_due [$];

  int mismatches      = 0;
  int words_sent      = 0;
  int bytes_checked   = 0;
  int frames_done     = 0;
  int settings_used   = 0;
  int src_gap_odds    = 0;
  int sink_gap_odds   = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int sink_stall_left = 0;
  int quiet_cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned smallest_lit(int unsigned r, int unsigned g, int unsigned b);
    int unsigned m;
    m = 0;
    if (r != 0) m = r;
    if (g != 0 && (m == 0 || g < m)) m = g;
    if (b != 0 && (m == 0 || b < m)) m = b;
    return m;
  endfunction

  function automatic int unsigned scale_divisor(int unsigned r, int unsigned g, int unsigned b);
    int unsigned m;
    int unsigned c;
    int unsigned d;
    d = 1;
    case (cfg_mode)
      MODE_FIXED: begin
        if (cfg_permille == 0) begin
          d = DIV_MAX;
        end else begin
          d = int'(PERMILLE_FULL) / int'(cfg_permille);
          if (d > DIV_MAX) d = DIV_MAX;
          if (d == 0) d = 1;
        end
      end
      MODE_PRESERVE: begin
        m = smallest_lit(r, g, b);
        if (m != 0) begin
          c = m * int'(cfg_permille) / int'(PERMILLE_FULL);
          if (c == 0) c = 1;
          if (c > m) c = m;
          d = m / c;
        end
      end
      default: begin
        d = 1;
      end
    endcase
    return d;
  endfunction

  function automatic frame_byte_t next_frame_byte();
    frame_byte_t      fb;
    int unsigned      pos;
    int unsigned      off;
    logic [PIX_W-1:0] colors;
    pos = byte_cursor;
    if (pos >= FRAME_LEN) pos = 0;
    fb.spi_byte = '0;
    if (pos >= PREAMBLE_BYTES_DEF) begin
      off = pos - PREAMBLE_BYTES_DEF;
      colors = led_colors[off / PIX_W];
      fb.spi_byte = colors[PIX_W - 1 - off % PIX_W] ? cfg_one : cfg_zero;
    end
    fb.last_of_frame = (pos == FRAME_LEN - 1);
    byte_cursor = fb.last_of_frame ? 0 : pos + 1;
    return fb;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CHAN_W'($urandom_range(1, 8));
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PERMILLE_W-1:0] rand_permille();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PERMILLE_W'(1);
      2: return PERMILLE_FULL;
      3: return '1;
      default: return PERMILLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // an accepted pull word queues its expected byte; an accepted in-range set word updates the pixel store
  always @(posedge clk) begin : predict_words
    int unsigned d;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    if (!rst && din_if.valid && din_if.ready) begin
      if (din_if.cmd == CMD_SET) begin
        if (din_if.led_index < LED_COUNT_DEF) begin
          r = din_if.red_in;
          g = din_if.green_in;
          b = din_if.blue_in;
          d = scale_divisor(r, g, b);
          led_colors[din_if.led_index] = {CHAN_W'(g / d), CHAN_W'(r / d), CHAN_W'(b / d)};
        end
      end else begin
        frame_bytes_due.push_back(next_frame_byte());
      end
    end
  end

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s wrong at byte %0d: expected 0x%0h, got 0x%0h", what, bytes_checked, want, got);
    end
  endtask

  always @(posedge clk) begin : check_bytes
    frame_byte_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (frame_bytes_due.size() == 0) begin
        note_mismatch("unexpected spi_byte", 0, dout_if.spi_byte);
      end else begin
        want = frame_bytes_due.pop_front();
        if (dout_if.spi_byte !== want.spi_byte) begin
          note_mismatch("spi_byte", want.spi_byte, dout_if.spi_byte);
        end
        if (dout_if.last_of_frame !== want.last_of_frame) begin
          note_mismatch("last_of_frame", want.last_of_frame, dout_if.last_of_frame);
        end
        if (want.last_of_frame) frames_done++;
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      dout_if.ready <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left--;
      dout_if.ready <= 1'b0;
    end else if (sink_gap_odds != 0 && $urandom_range(0, sink_gap_odds) == 0) begin
      sink_stall_left = $urandom_range(0, 15);
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgb_led_strip_spi_encoder: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:     cfg_mode     = value[MODE_W-1:0];
      REG_PERMILLE: cfg_permille = value[PERMILLE_W-1:0];
      REG_ZERO_PAT: cfg_zero     = value[PAT_W-1:0];
      REG_ONE_PAT:  cfg_one      = value[PAT_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [MODE_W-1:0] mode, logic [PERMILLE_W-1:0] permille,
                            logic [PAT_W-1:0] zero_pat, logic [PAT_W-1:0] one_pat);
    write_reg(REG_MODE, APB_DATA_W'(mode));
    write_reg(REG_PERMILLE, APB_DATA_W'(permille));
    write_reg(REG_ZERO_PAT, APB_DATA_W'(zero_pat));
    write_reg(REG_ONE_PAT, APB_DATA_W'(one_pat));
    settings_used++;
  endtask

  task automatic send_word(logic cmd, logic [INDEX_W-1:0] idx,
                           logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    if (src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
      din_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.cmd       <= cmd;
    din_if.led_index <= idx;
    din_if.red_in    <= r;
    din_if.green_in  <= g;
    din_if.blue_in   <= b;
    do @(posedge clk); while (!din_if.ready);
    if (cmd == CMD_PULL || idx < LED_COUNT_DEF) words_sent++;
  endtask

  task automatic send_random_word();
    logic [INDEX_W-1:0] idx;
    if ($urandom_range(0, 9) != 0) begin
      send_word(CMD_PULL, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom));
    end else begin
      if ($urandom_range(0, 7) == 0) idx = INDEX_W'($urandom_range(LED_COUNT_DEF, 1023));
      else idx = INDEX_W'($urandom_range(0, LED_COUNT_DEF - 1));
      send_word(CMD_SET, idx, rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  // a set word gives no byte, so let the divider finish before touching registers
  task automatic wait_drained();
    din_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_index_range();
    send_word(CMD_SET, '0, '1, '1, '1);
    send_word(CMD_SET, INDEX_W'(LED_COUNT_DEF - 1), 8'd1, 8'd2, 8'd3);
    send_word(CMD_SET, INDEX_W'(LED_COUNT_DEF), 8'd9, 8'd9, 8'd9);
    send_word(CMD_SET, '1, 8'd255, 8'd0, 8'd255);
    send_word(CMD_SET, INDEX_W'(1), '0, '0, '0);
    send_word(CMD_PULL, '1, '1, '1, '1);
    send_word(CMD_PULL, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic dim_case(logic [MODE_W-1:0] mode, logic [PERMILLE_W-1:0] permille,
                          logic [INDEX_W-1:0] idx,
                          logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    set_config(mode, permille, PAT_W'($urandom), PAT_W'($urandom));
    send_word(CMD_SET, idx, r, g, b);
    wait_drained();
  endtask

  task automatic test_dimming_modes();
    dim_case(MODE_NONE, PERMILLE_FULL, 10'd2, 8'd200, 8'd100, 8'd1);
    dim_case(MODE_FIXED, 10'd1, 10'd3, 8'd255, 8'd17, 8'd254);
    dim_case(MODE_FIXED, 10'd0, 10'd4, 8'd255, 8'd128, 8'd3);
    dim_case(MODE_FIXED, 10'd1023, 10'd5, 8'd77, 8'd0, 8'd255);
    dim_case(MODE_PRESERVE, 10'd0, 10'd6, 8'd40, 8'd0, 8'd12);
    dim_case(MODE_PRESERVE, 10'd1023, 10'd7, 8'd3, 8'd250, 8'd0);
    dim_case(MODE_PRESERVE, 10'd500, 10'd8, 8'd0, 8'd0, 8'd0);
    dim_case(MODE_SPARE, 10'd500, 10'd9, 8'd33, 8'd66, 8'd99);
  endtask

  // receiver holds off while pulls keep coming, so the input side backs up
  task automatic test_output_backpressure();
    src_gap_odds = 0;
    hold_request = 400;
    repeat (24) send_word(CMD_PULL, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_phases();
    while (words_sent < WORD_GOAL - PHASE_WORDS || frames_done < 1) begin
      set_config(MODE_W'($urandom_range(0, 3)), rand_permille(),
                 $urandom_range(0, 3) == 0 ? '0 : PAT_W'($urandom),
                 $urandom_range(0, 3) == 0 ? '1 : PAT_W'($urandom));
      src_gap_odds  = $urandom_range(0, 3) * 4;
      sink_gap_odds = $urandom_range(0, 3) * 4;
      repeat (PHASE_WORDS) send_random_word();
      wait_drained();
    end
    src_gap_odds  = 0;
    sink_gap_odds = 0;
    set_config(MODE_PRESERVE, PERMILLE_W'($urandom_range(1, 1000)), ZERO_PAT_RST, ONE_PAT_RST);
    repeat (PHASE_WORDS) send_random_word();
    wait_drained();
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    din_if.valid     = 1'b0;
    din_if.cmd       = CMD_SET;
    din_if.led_index = '0;
    din_if.red_in    = '0;
    din_if.green_in  = '0;
    din_if.blue_in   = '0;
    dout_if.ready    = 1'b0;
    for (int i = 0; i < LED_COUNT_DEF; i++) led_colors[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_index_range();
    test_dimming_modes();
    test_output_backpressure();
    test_random_phases();
    $display("covered %0d words over %0d register settings", words_sent, settings_used);
    $display("checked %0d frame bytes across %0d full frames", bytes_checked, frames_done);
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("rgb_led_strip_spi_encoder: match");
    end else begin
      $display("rgb_led_strip_spi_encoder: mismatch");
    end
    $finish;
  end

endmodule
